// ===== rtl/spq_pkg.sv =====
package spq_pkg;

	localparam int unsigned DEPTH_DEFAULT = 16;
	localparam int unsigned POS_W = 5;
	localparam int unsigned DATA_W = 32;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_DELETE = 2'd1,
		KIND_PEEK   = 2'd2,
		KIND_SPARE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_BADPOS = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]               kind;
		logic signed [DATA_W-1:0] item_value;
		logic signed [DATA_W-1:0] item_priority;
		logic [POS_W-1:0]         position;
	} in_item_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] head_value;
		logic signed [DATA_W-1:0] head_priority;
		logic signed [DATA_W-1:0] tail_value;
		logic signed [DATA_W-1:0] tail_priority;
		logic [POS_W-1:0]         occupancy;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load;   // capture the input item
		logic exec;   // apply the operation and build the result
	} dp_cmd_t;

endpackage

// ===== rtl/spq_datapath.sv =====
module spq_datapath #(
	parameter int unsigned DEPTH = spq_pkg::DEPTH_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  spq_pkg::dp_cmd_t   cmd,
	input  spq_pkg::in_item_t  in_item,
	output spq_pkg::out_item_t result
);
	import spq_pkg::*;

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	logic signed [DATA_W-1:0] val_q [DEPTH];
	logic signed [DATA_W-1:0] pri_q [DEPTH];
	logic [CNT_W-1:0]         count_q;
	in_item_t                 op_q;
	out_item_t                result_q;

	logic [DEPTH-1:0]   greater;   // entry priority above the new one, within count
	logic [DEPTH-1:0]   del_mask;  // entry at or past the deleted position
	logic [CNT_W-1:0]   next_count;
	logic [1:0]         status;
	logic               do_ins;
	logic               do_del;
	logic [CMP_W-1:0]   pos_ext;

	always_comb begin
		pos_ext = CMP_W'(op_q.position);
		for (int i = 0; i < DEPTH; i++) begin
			greater[i]  = (i < count_q) && (pri_q[i] > op_q.item_priority);
			del_mask[i] = ((i + 1) >= pos_ext);
		end
		do_ins = 1'b0;
		do_del = 1'b0;
		next_count = count_q;
		case (op_q.kind)
			KIND_INSERT: begin
				if (count_q == CNT_W'(DEPTH)) begin
					status = ST_FULL;
				end else begin
					status = ST_OK;
					do_ins = 1'b1;
					next_count = count_q + 1'b1;
				end
			end
			KIND_DELETE: begin
				if (count_q == '0) begin
					status = ST_EMPTY;
				end else if (pos_ext == '0 || pos_ext > CMP_W'(count_q)) begin
					status = ST_BADPOS;
				end else begin
					status = ST_OK;
					do_del = 1'b1;
					next_count = count_q - 1'b1;
				end
			end
			default: status = (count_q == '0) ? ST_EMPTY : ST_OK;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= in_item;
		end
		if (cmd.exec) begin
			for (int i = 0; i < DEPTH; i++) begin
				if (do_ins && (greater[i] || i == count_q)) begin
					// shift up, new entry lands in the first greater slot or at the end
					if (i == 0 || !greater[i-1]) begin
						val_q[i] <= op_q.item_value;
						pri_q[i] <= op_q.item_priority;
					end else begin
						val_q[i] <= val_q[i-1];
						pri_q[i] <= pri_q[i-1];
					end
				end else if (do_del && del_mask[i] && i + 1 < DEPTH) begin
					val_q[i] <= val_q[i+1];
					pri_q[i] <= pri_q[i+1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			count_q <= next_count;
		end
	end

	// head and tail read after the update in the following cycle
	logic [$clog2(DEPTH)-1:0] tail_idx;
	logic [1:0]               status_s1;

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_s1 <= status;
		end
	end

	always_comb begin
		tail_idx = $clog2(DEPTH)'(count_q - 1'b1);
		result_q.status    = status_s1;
		result_q.occupancy = POS_W'(count_q);
		if (count_q == '0) begin
			result_q.head_value    = '0;
			result_q.head_priority = '0;
			result_q.tail_value    = '0;
			result_q.tail_priority = '0;
		end else begin
			result_q.head_value    = val_q[0];
			result_q.head_priority = pri_q[0];
			result_q.tail_value    = val_q[tail_idx];
			result_q.tail_priority = pri_q[tail_idx];
		end
	end

	assign result = result_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH)) else $error("count beyond depth");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.exec |=> (count_q == $past(count_q))) else $error("count moved while idle");
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && status == ST_FULL |=> count_q == CNT_W'(DEPTH))
		else $error("full insert changed count");
`endif

endmodule

// ===== rtl/spq_ctrl.sv =====
module spq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output spq_pkg::dp_cmd_t cmd
);
	import spq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_SEND = 3'b100
	} state_t;

	state_t state_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_SEND);
	assign cmd.load  = in_valid && in_ready;
	assign cmd.exec  = (state_q == S_EXEC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_EXEC;
				S_EXEC: state_q <= S_SEND;
				S_SEND: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state not one-hot");
	a_exec_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.exec) else $error("load not followed by exec");
	a_send_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> out_valid) else $error("exec not followed by result");
`endif

endmodule

// ===== rtl/sorted_priority_queue_top.sv =====
// channel | valid     | ready     | payload
// in      | in_valid  | in_ready  | in_item  (kind, value, priority, position)
// out     | out_valid | out_ready | out_item (status, head, tail, occupancy)
// Each operation goes through capture, update and present; present waits out any output stall.
// The sorted store shifts all entries at once with a compare per slot.
// Reset empties the store; entry contents are not cleared.
// A new item waits until the result of the last one is transferred.
module sorted_priority_queue_top #(
	parameter int unsigned DEPTH = spq_pkg::DEPTH_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  spq_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output spq_pkg::out_item_t out_item
);
	import spq_pkg::*;

	dp_cmd_t cmd;

	spq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .cmd(cmd)
	);

	spq_datapath #(.DEPTH(DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .in_item(in_item), .result(out_item)
	);

endmodule

// ===== test/sorted_priority_queue_top_tb.sv =====
`timescale 1ns / 1ps

module sorted_priority_queue_top_tb;
	import spq_pkg::*;

	localparam int unsigned QDEPTH = 16;
	localparam int unsigned CYCLE_LIMIT = 200000;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_item;

	sorted_priority_queue_top #(.DEPTH(QDEPTH)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);

	// queue model state
	logic signed [31:0] q_val [QDEPTH];
	logic signed [31:0] q_pri [QDEPTH];
	int unsigned        q_cnt;

	in_item_t  pending_ops[$];
	out_item_t expected_results[$];
	int unsigned mismatches;
	int unsigned cycles;
	int unsigned results_seen;
	int unsigned n_full, n_empty, n_badpos;
	bit          quiet_mode;    // no idling on either side
	bit          sender_hold;
	int unsigned hold_off;      // receiver hold-off counter

	function automatic out_item_t apply_op(in_item_t op);
		out_item_t r;
		int unsigned at;
		r = '0;
		r.status = ST_OK;
		case (kind_t'(op.kind))
		KIND_INSERT: begin
			if (q_cnt >= QDEPTH) begin
				r.status = ST_FULL;
			end else begin
				at = q_cnt;
				for (int i = q_cnt - 1; i >= 0; i--)
					if (q_pri[i] > op.item_priority)
						at = i;
				for (int i = q_cnt; i > at; i--) begin
					q_val[i] = q_val[i-1];
					q_pri[i] = q_pri[i-1];
				end
				q_val[at] = op.item_value;
				q_pri[at] = op.item_priority;
				q_cnt++;
			end
		end
		KIND_DELETE: begin
			if (q_cnt == 0)
				r.status = ST_EMPTY;
			else if (op.position == 0 || op.position > q_cnt)
				r.status = ST_BADPOS;
			else begin
				for (int i = op.position - 1; i + 1 < q_cnt; i++) begin
					q_val[i] = q_val[i+1];
					q_pri[i] = q_pri[i+1];
				end
				q_cnt--;
			end
		end
		default: begin
			if (q_cnt == 0)
				r.status = ST_EMPTY;
		end
		endcase
		if (q_cnt > 0) begin
			r.head_value    = q_val[0];
			r.head_priority = q_pri[0];
			r.tail_value    = q_val[q_cnt-1];
			r.tail_priority = q_pri[q_cnt-1];
		end
		r.occupancy = q_cnt[4:0];
		return r;
	endfunction

	function automatic in_item_t make_op(kind_t k, logic [31:0] v, logic [31:0] p,
			logic [4:0] pos);
		in_item_t op;
		op.kind = k;
		op.item_value = v;
		op.item_priority = p;
		op.position = pos;
		return op;
	endfunction

	// priorities often drawn from a small set so that ties occur
	function automatic logic [31:0] rand_prio();
		case ($urandom_range(0, 3))
		0: return $urandom;
		1: return 32'h8000_0000 + $urandom_range(0, 3);
		2: return 32'h7fff_ffff - $urandom_range(0, 3);
		default: return $urandom_range(0, 7) - 4;
		endcase
	endfunction

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item  <= '0;
		end else begin
			if (!in_valid || in_ready) begin
				if (pending_ops.size() > 0 && !sender_hold
						&& (quiet_mode || $urandom_range(0, 99) >= 34)) begin
					in_valid <= 1'b1;
					in_item  <= pending_ops.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
			if (in_valid && in_ready)
				expected_results.push_back(apply_op(in_item));
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_r;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= quiet_mode || $urandom_range(0, 99) >= 34;
			end
			if (out_valid && out_ready) begin
				results_seen <= results_seen + 1;
				if (expected_results.size() == 0) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("unexpected result %p", out_item);
				end else begin
					exp_r = expected_results.pop_front();
					case (status_t'(exp_r.status))
					ST_FULL:   n_full <= n_full + 1;
					ST_EMPTY:  n_empty <= n_empty + 1;
					ST_BADPOS: n_badpos <= n_badpos + 1;
					default: ;
					endcase
					if (out_item !== exp_r) begin
						mismatches <= mismatches + 1;
						if (mismatches < 10)
							$display("mismatch: expected %p, got %p", exp_r, out_item);
					end
				end
			end
		end
	end

	task automatic wait_drained();
		while (pending_ops.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		in_item_t op;
		int unsigned r;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_ready = 1'b0;
		cycles = 0;
		mismatches = 0;
		results_seen = 0;
		n_full = 0; n_empty = 0; n_badpos = 0;
		quiet_mode = 1'b0;
		sender_hold = 1'b0;
		hold_off = 0;
		q_cnt = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty cases, extremes, ties, full, bad positions
		pending_ops.push_back(make_op(KIND_PEEK, 0, 0, 0));
		pending_ops.push_back(make_op(KIND_DELETE, 0, 0, 1));
		pending_ops.push_back(make_op(KIND_SPARE, '1, '1, '1));
		pending_ops.push_back(make_op(KIND_INSERT, 32'h7fff_ffff, 32'h7fff_ffff, 0));
		pending_ops.push_back(make_op(KIND_INSERT, 32'h8000_0000, 32'h8000_0000, 5'h1f));
		pending_ops.push_back(make_op(KIND_INSERT, 32'h1, 32'h8000_0000, 0));
		pending_ops.push_back(make_op(KIND_INSERT, '1, '1, 0));
		pending_ops.push_back(make_op(KIND_DELETE, 0, 0, 0));
		pending_ops.push_back(make_op(KIND_DELETE, 0, 0, 5));
		pending_ops.push_back(make_op(KIND_DELETE, 0, 0, 5'h1f));
		pending_ops.push_back(make_op(KIND_DELETE, 0, 0, 4));
		pending_ops.push_back(make_op(KIND_DELETE, 0, 0, 1));
		for (int i = 0; i < 15; i++)
			pending_ops.push_back(make_op(KIND_INSERT, $urandom, rand_prio(), 0));
		pending_ops.push_back(make_op(KIND_INSERT, 32'h5a5a_5a5a, 0, 0));
		pending_ops.push_back(make_op(KIND_DELETE, 0, 0, 16));
		pending_ops.push_back(make_op(KIND_DELETE, 0, 0, 17));
		wait_drained();

		// random: phases of fill and drain with random content
		for (int ph = 0; ph < 10; ph++) begin
			quiet_mode = (ph == 3);
			if (ph == 5)
				hold_off = 400;
			for (int n = 0; n < 100; n++) begin
				r = $urandom_range(0, 99);
				if (r < ((ph % 2) ? 30 : 60))
					op = make_op(KIND_INSERT, $urandom, rand_prio(), 5'($urandom));
				else if (r < 90)
					op = make_op(KIND_DELETE, $urandom, $urandom,
						5'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 17)));
				else
					op = make_op(kind_t'($urandom_range(2, 3)), $urandom, $urandom,
						5'($urandom));
				pending_ops.push_back(op);
			end
			// keep the no-idle stretch running until its items are through
			if (ph == 3)
				wait_drained();
			if (ph == 6) begin
				// pause the sender until every result is in
				while (pending_ops.size() > 0) @(posedge clk);
				sender_hold = 1'b1;
				wait_drained();
				repeat (20) @(posedge clk);
				sender_hold = 1'b0;
			end
		end
		wait_drained();
		repeat (20) @(posedge clk);

		$display("%0d results checked; full %0d, empty %0d, bad position %0d",
			results_seen, n_full, n_empty, n_badpos);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
